// ===== hw/rtl/opwf_pkg.sv =====
`default_nettype none

package opwf_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_LEVEL_COUNT  = 2'd2
  } cfg_reg_e;

  localparam int unsigned CfgDataW = 12;
  localparam int unsigned CellCount = 9;

  typedef struct packed {
    logic [7:0] pix_red;
    logic [7:0] pix_green;
    logic [7:0] pix_blue;
  } pix_t;

  typedef struct packed {
    logic [10:0] out_col;
    logic [11:0] out_row;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic        frame_done;
  } res_t;

  // One window pixel with its channel mean
  typedef struct packed {
    logic [7:0] mean;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cell_t;

  typedef struct packed {
    cell_t [CellCount-1:0] tap;
    logic [10:0]           col;
    logic [11:0]           row;
    logic                  done;
  } win_t;

  // floor((r+g+b)/3) via reciprocal multiply, exact for sums up to 765
  function automatic logic [7:0] mean3(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
    logic [9:0]  sum;
    logic [19:0] prod;
    sum  = 10'(r) + 10'(g) + 10'(b);
    prod = 20'(sum) * 20'd683;
    return prod[18:11];
  endfunction

  // ceil(2^16 / c) for member counts 1..9
  function automatic logic [16:0] recip(input logic [3:0] c);
    logic [16:0] v;
    case (c)
      4'd2:    v = 17'd32768;
      4'd3:    v = 17'd21846;
      4'd4:    v = 17'd16384;
      4'd5:    v = 17'd13108;
      4'd6:    v = 17'd10923;
      4'd7:    v = 17'd9363;
      4'd8:    v = 17'd8192;
      4'd9:    v = 17'd7282;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/opwf_front.sv =====
`default_nettype none

module opwf_front #(
  parameter int unsigned MAX_LINE = 2048,
  localparam int unsigned LW = $clog2(MAX_LINE + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            pix_valid_i,
  input  wire opwf_pkg::pix_t  pix_i,
  output logic                 pix_ready_o,
  input  wire logic [LW-1:0]   eff_width_i,
  input  wire logic [11:0]     eff_height_i,
  input  wire logic            restart_i,
  output logic                 push_o,
  output opwf_pkg::win_t       item_o,
  input  wire logic            push_ready_i
);
  import opwf_pkg::*;

  localparam int unsigned CW = $clog2(MAX_LINE);

  typedef enum logic {F_IDLE, F_WR} fstate_e;

  fstate_e         st_q;
  logic [CW-1:0]   col_q;
  logic [11:0]     row_q;
  cell_t           pix_q;
  cell_t           top_q, mid_q;
  cell_t           win_q [CellCount];
  cell_t           win_n [CellCount];
  cell_t           mem_top [MAX_LINE];
  cell_t           mem_mid [MAX_LINE];
  logic            interior, wr_go, col_last, row_last;

  assign pix_ready_o = (st_q == F_IDLE);
  assign interior    = (col_q >= CW'(2)) && (row_q >= 12'd2);
  assign push_o      = (st_q == F_WR) && interior;
  assign wr_go       = (st_q == F_WR) && (!interior || push_ready_i);
  assign col_last    = (LW'(col_q) + LW'(1)) >= eff_width_i;
  assign row_last    = (13'(row_q) + 13'd1) >= {1'b0, eff_height_i};

  // Shift window left, new column enters on the right
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_n[r*3]   = win_q[r*3+1];
      win_n[r*3+1] = win_q[r*3+2];
    end
    win_n[2] = top_q;
    win_n[5] = mid_q;
    win_n[8] = pix_q;
    for (int i = 0; i < CellCount; i++) begin
      item_o.tap[i] = win_n[i];
    end
    item_o.col  = 11'(col_q - CW'(1));
    item_o.row  = row_q - 12'd1;
    item_o.done = col_last && row_last;
  end

  // Line stores: read the current column every cycle, write on retire
  always_ff @(posedge clk_i) begin
    top_q <= mem_top[col_q];
    mid_q <= mem_mid[col_q];
    if (wr_go) begin
      mem_top[col_q] <= mid_q;
      mem_mid[col_q] <= pix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_valid_i && pix_ready_o) begin
      pix_q <= '{mean:  mean3(pix_i.pix_red, pix_i.pix_green, pix_i.pix_blue),
                 red:   pix_i.pix_red,
                 green: pix_i.pix_green,
                 blue:  pix_i.pix_blue};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= F_IDLE;
      col_q <= '0;
      row_q <= '0;
      for (int i = 0; i < CellCount; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      case (st_q)
        F_IDLE: begin
          if (pix_valid_i) begin
            st_q <= F_WR;
          end
        end
        F_WR: begin
          if (wr_go) begin
            st_q <= F_IDLE;
            for (int i = 0; i < CellCount; i++) begin
              win_q[i] <= win_n[i];
            end
            if (col_last) begin
              col_q <= '0;
              row_q <= row_last ? 12'd0 : row_q + 12'd1;
            end else begin
              col_q <= col_q + CW'(1);
            end
          end
        end
        default: st_q <= F_IDLE;
      endcase
      if (restart_i) begin
        col_q <= '0;
        row_q <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/opwf_fifo.sv =====
`default_nettype none

module opwf_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire opwf_pkg::win_t data_i,
  output logic                ready_o,
  output logic                avail_o,
  input  wire logic           pop_i,
  output opwf_pkg::win_t      data_o
);
  import opwf_pkg::*;

  win_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign ready_o = (cnt_q != 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && avail_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/opwf_back.sv =====
`default_nettype none

module opwf_back #(
  parameter int unsigned MAX_LEVELS = 16,
  localparam int unsigned LVW = $clog2(MAX_LEVELS + 1)
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [LVW-1:0] eff_levels_i,
  input  wire logic           avail_i,
  input  wire opwf_pkg::win_t item_i,
  output logic                pop_o,
  output opwf_pkg::res_t      res_o,
  output logic                res_valid_o,
  input  wire logic           res_ready_i
);
  import opwf_pkg::*;

  localparam int unsigned BW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  typedef enum logic [1:0] {B_IDLE, B_BIN, B_SRCH, B_DIV} bstate_e;

  bstate_e         st_q;
  win_t            cur_q;
  logic [3:0]      cell_idx_q;
  logic [LVW-1:0]  lvl_q;
  logic [1:0]      ch_q;
  logic [3:0]      cnt_q [MAX_LEVELS];
  logic [11:0]     sr_q [MAX_LEVELS];
  logic [11:0]     sg_q [MAX_LEVELS];
  logic [11:0]     sb_q [MAX_LEVELS];
  logic [3:0]      best_q;
  logic [BW-1:0]   bidx_q;
  logic [7:0]      red_q, green_q;
  res_t            res_q;
  logic            res_valid_q;

  cell_t           tap;
  logic [15:0]     lv_prod, lv_quo;
  logic [BW-1:0]   bin, addr;
  logic [11:0]     div_s;
  logic [28:0]     div_prod;
  logic [7:0]      div_q;
  logic            out_free;
  logic            res_load;

  assign pop_o       = (st_q == B_IDLE) && avail_i;
  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;
  assign out_free    = !res_valid_q || res_ready_i;
  assign res_load    = (st_q == B_DIV) && (ch_q >= 2'd2) && out_free;

  always_comb begin
    tap     = cur_q.tap[cell_idx_q];
    lv_prod = 16'(tap.mean) * 16'(eff_levels_i);
    // exact divide by 255 for values below 65280
    lv_quo  = (lv_prod + (lv_prod >> 8) + 16'd1) >> 8;
    if (lv_quo >= 16'(eff_levels_i)) begin
      bin = BW'(eff_levels_i - LVW'(1));
    end else begin
      bin = BW'(lv_quo);
    end
    case (st_q)
      B_BIN:   addr = bin;
      B_SRCH:  addr = BW'(lvl_q);
      default: addr = bidx_q;
    endcase
    case (ch_q)
      2'd0:    div_s = sr_q[addr];
      2'd1:    div_s = sg_q[addr];
      default: div_s = sb_q[addr];
    endcase
    div_prod = 29'(div_s) * 29'(recip(best_q));
    div_q    = div_prod[23:16];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      cell_idx_q  <= '0;
      lvl_q       <= '0;
      ch_q        <= '0;
      best_q      <= '0;
      bidx_q      <= '0;
      red_q       <= '0;
      green_q     <= '0;
      res_q       <= '0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        cnt_q[i] <= '0;
        sr_q[i]  <= '0;
        sg_q[i]  <= '0;
        sb_q[i]  <= '0;
      end
    end else begin
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_valid_q && res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      case (st_q)
        B_IDLE: begin
          if (avail_i) begin
            st_q       <= B_BIN;
            cell_idx_q <= '0;
            for (int i = 0; i < MAX_LEVELS; i++) begin
              cnt_q[i] <= '0;
              sr_q[i]  <= '0;
              sg_q[i]  <= '0;
              sb_q[i]  <= '0;
            end
          end
        end
        B_BIN: begin
          cnt_q[addr] <= cnt_q[addr] + 4'd1;
          sr_q[addr]  <= sr_q[addr] + 12'(tap.red);
          sg_q[addr]  <= sg_q[addr] + 12'(tap.green);
          sb_q[addr]  <= sb_q[addr] + 12'(tap.blue);
          cell_idx_q  <= cell_idx_q + 4'd1;
          if (cell_idx_q == 4'(CellCount - 1)) begin
            st_q   <= B_SRCH;
            lvl_q  <= '0;
            best_q <= '0;
            bidx_q <= '0;
          end
        end
        B_SRCH: begin
          if (cnt_q[addr] > best_q) begin
            best_q <= cnt_q[addr];
            bidx_q <= addr;
          end
          lvl_q <= lvl_q + LVW'(1);
          if (lvl_q == eff_levels_i - LVW'(1)) begin
            st_q <= B_DIV;
            ch_q <= 2'd0;
          end
        end
        B_DIV: begin
          case (ch_q)
            2'd0: begin
              red_q <= div_q;
              ch_q  <= 2'd1;
            end
            2'd1: begin
              green_q <= div_q;
              ch_q    <= 2'd2;
            end
            default: begin
              if (out_free) begin
                res_q       <= '{out_col: cur_q.col, out_row: cur_q.row,
                                 out_red: red_q, out_green: green_q,
                                 out_blue: div_q, frame_done: cur_q.done};
                ch_q        <= 2'd0;
                st_q        <= B_IDLE;
              end
            end
          endcase
        end
        default: st_q <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/oil_painting_window_filter.sv =====
// Channel   Direction  Handshake                Payload
// pixel     in         pix_valid_i/pix_ready_o  pix_i   (red, green, blue)
// result    out        res_valid_o/res_ready_i  res_o   (col, row, red, green, blue, done)
// config    in         cfg_we_i                 cfg_idx_i, cfg_data_i
//
// Every pixel passes two front-end steps: transfer and line-store read, then write and
// window shift; for interior pixels the second step holds while the window queue is full.
// Interior pixels then pass the back end as one pop step, one binning step per window pixel,
// one search step per level of the clamped level count and one divide step per channel.
// A two-entry window queue sits between them; the result register holds.
// Reset clears counters, window and handshake state; line stores start undefined.
`default_nettype none

module oil_painting_window_filter #(
  parameter int unsigned MAX_LINE   = 2048,
  parameter int unsigned MAX_LEVELS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          pix_valid_i,
  input  wire opwf_pkg::pix_t                pix_i,
  output logic                               pix_ready_o,
  output logic                               res_valid_o,
  output opwf_pkg::res_t                     res_o,
  input  wire logic                          res_ready_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_idx_i,
  input  wire logic [opwf_pkg::CfgDataW-1:0] cfg_data_i
);
  import opwf_pkg::*;

  localparam int unsigned LW  = $clog2(MAX_LINE + 1);
  localparam int unsigned LVW = $clog2(MAX_LEVELS + 1);

  logic [11:0]    width_q, height_q;
  logic [4:0]     levels_q;
  logic [LW-1:0]  eff_w;
  logic [11:0]    eff_h;
  logic [LVW-1:0] eff_lv;
  logic           restart;

  logic           push, push_ready, avail, pop;
  win_t           push_item, pop_item;

  // Configuration registers; a new frame size restarts the raster position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 12'd640;
      height_q <= 12'd480;
      levels_q <= 5'd10;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        REG_LEVEL_COUNT:  levels_q <= cfg_data_i[4:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  assign restart = cfg_we_i &&
                   (cfg_idx_i == REG_FRAME_WIDTH || cfg_idx_i == REG_FRAME_HEIGHT);

  // Clamp register values into their working ranges
  always_comb begin
    if (32'(width_q) < 32'd3) begin
      eff_w = LW'(3);
    end else if (32'(width_q) > MAX_LINE) begin
      eff_w = LW'(MAX_LINE);
    end else begin
      eff_w = LW'(width_q);
    end
    eff_h = (height_q < 12'd3) ? 12'd3 : height_q;
    if (levels_q == 5'd0) begin
      eff_lv = LVW'(1);
    end else if (32'(levels_q) > MAX_LEVELS) begin
      eff_lv = LVW'(MAX_LEVELS);
    end else begin
      eff_lv = LVW'(levels_q);
    end
  end

  opwf_front #(.MAX_LINE(MAX_LINE)) u_front (
    .clk_i,
    .rst_ni,
    .pix_valid_i,
    .pix_i,
    .pix_ready_o,
    .eff_width_i  (eff_w),
    .eff_height_i (eff_h),
    .restart_i    (restart),
    .push_o       (push),
    .item_o       (push_item),
    .push_ready_i (push_ready)
  );

  opwf_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  (push_item),
    .ready_o (push_ready),
    .avail_o (avail),
    .pop_i   (pop),
    .data_o  (pop_item)
  );

  opwf_back #(.MAX_LEVELS(MAX_LEVELS)) u_back (
    .clk_i,
    .rst_ni,
    .eff_levels_i (eff_lv),
    .avail_i      (avail),
    .item_i       (pop_item),
    .pop_o        (pop),
    .res_o,
    .res_valid_o,
    .res_ready_i
  );

endmodule

`default_nettype wire

// ===== hw/rtl/opwf_checker.sv =====
`default_nettype none

module opwf_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          pix_valid_i,
  input wire logic                          pix_ready_o,
  input wire logic                          res_valid_o,
  input wire opwf_pkg::res_t                res_o,
  input wire logic                          res_ready_i
);
  import opwf_pkg::*;

  // A stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(res_o))
    else $error("result changed while stalled");

  // Interior centres never sit on row zero
  a_row_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.out_row != 12'd0)
    else $error("result on border row");

  // Nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !res_valid_o)
    else $error("result right after reset");

  // A pixel never enters the cycle after another one
  a_pix_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && pix_ready_o |=> !pix_ready_o)
    else $error("pixel accepted back to back");

endmodule

bind oil_painting_window_filter opwf_checker u_opwf_checker (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none

// Scoreboard: tracks the filter state and holds the filtered pixels still owed.
class oil_scoreboard;
  logic [23:0] line_mem [2][2048];
  logic [23:0] win [3][3];
  int unsigned col_cnt, row_cnt;
  int unsigned width_reg, height_reg, levels_reg;
  opwf_pkg::res_t owed[$];
  int unsigned errors, matched, pixels;

  function new();
    width_reg = 640;
    height_reg = 480;
    levels_reg = 10;
    col_cnt = 0;
    row_cnt = 0;
    errors = 0;
    matched = 0;
    pixels = 0;
    foreach (win[r, c]) win[r][c] = '0;
    foreach (line_mem[r, c]) line_mem[r][c] = '0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [11:0] val);
    case (idx)
      opwf_pkg::REG_FRAME_WIDTH: begin
        width_reg = val;
        col_cnt = 0;
        row_cnt = 0;
      end
      opwf_pkg::REG_FRAME_HEIGHT: begin
        height_reg = val;
        col_cnt = 0;
        row_cnt = 0;
      end
      opwf_pkg::REG_LEVEL_COUNT: levels_reg = val[4:0];
      default: ;
    endcase
  endfunction

  // Advance the window by one input pixel and queue the filtered result, if any.
  function void note_pixel(opwf_pkg::pix_t p);
    int unsigned w, h, lv, ci, bin, best, bidx, mr, mg, mb;
    int unsigned cnt [16];
    int unsigned sr [16];
    int unsigned sg [16];
    int unsigned sb [16];
    logic [23:0] top, mid, cur, q;
    opwf_pkg::res_t r;
    w = (width_reg < 3) ? 3 : (width_reg > 2048) ? 2048 : width_reg;
    h = (height_reg < 3) ? 3 : height_reg;
    lv = (levels_reg < 1) ? 1 : (levels_reg > 16) ? 16 : levels_reg;
    pixels++;
    cur = p;
    ci = col_cnt % 2048;
    top = line_mem[0][ci];
    mid = line_mem[1][ci];
    line_mem[0][ci] = mid;
    line_mem[1][ci] = cur;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = cur;
    if (col_cnt >= 2 && row_cnt >= 2) begin
      for (int k = 0; k < 16; k++) begin
        cnt[k] = 0;
        sr[k] = 0;
        sg[k] = 0;
        sb[k] = 0;
      end
      foreach (win[i, j]) begin
        q = win[i][j];
        mr = q[23:16];
        mg = q[15:8];
        mb = q[7:0];
        bin = (((mr + mg + mb) / 3) * lv) / 255;
        if (bin > lv - 1) bin = lv - 1;
        cnt[bin]++;
        sr[bin] += mr;
        sg[bin] += mg;
        sb[bin] += mb;
      end
      best = 0;
      bidx = 0;
      for (int k = 0; k < lv; k++)
        if (cnt[k] > best) begin
          best = cnt[k];
          bidx = k;
        end
      r.out_col = 11'(col_cnt - 1);
      r.out_row = 12'(row_cnt - 1);
      r.out_red = 8'(sr[bidx] / best);
      r.out_green = 8'(sg[bidx] / best);
      r.out_blue = 8'(sb[bidx] / best);
      r.frame_done = (col_cnt + 1 >= w) && (row_cnt + 1 >= h);
      owed.push_back(r);
    end
    if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
    end else begin
      col_cnt++;
    end
  endfunction

  function void check_result(opwf_pkg::res_t got);
    opwf_pkg::res_t want;
    if (owed.size() == 0) begin
      $display("%0t: result expected none actual %h", $time, got);
      errors++;
      return;
    end
    want = owed.pop_front();
    matched++;
    if (got.out_col !== want.out_col) begin
      $display("%0t: col expected %0d actual %0d", $time, want.out_col, got.out_col);
      errors++;
    end
    if (got.out_row !== want.out_row) begin
      $display("%0t: row expected %0d actual %0d", $time, want.out_row, got.out_row);
      errors++;
    end
    if (got.out_red !== want.out_red) begin
      $display("%0t: red expected %0d actual %0d", $time, want.out_red, got.out_red);
      errors++;
    end
    if (got.out_green !== want.out_green) begin
      $display("%0t: green expected %0d actual %0d", $time, want.out_green, got.out_green);
      errors++;
    end
    if (got.out_blue !== want.out_blue) begin
      $display("%0t: blue expected %0d actual %0d", $time, want.out_blue, got.out_blue);
      errors++;
    end
    if (got.frame_done !== want.frame_done) begin
      $display("%0t: frame_done expected %0b actual %0b", $time, want.frame_done,
               got.frame_done);
      errors++;
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import opwf_pkg::*;

  // Index with no register behind it; the block must ignore writes to it.
  localparam logic [1:0] RegSpare = 2'd3;
  // Cycles to let a trailing border pixel drain; it passes only the front end, not queue or back end.
  localparam int unsigned DrainCycles = 128;

  logic clk_i;
  logic rst_ni;
  logic pix_valid_i;
  pix_t pix_i;
  logic pix_ready_o;
  logic res_valid_o;
  res_t res_o;
  logic res_ready_i;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Set during a stretch of the run in which neither side idles.
  bit steady;
  int unsigned phases;
  oil_scoreboard board;

  oil_painting_window_filter dut (
    .clk_i,
    .rst_ni,
    .pix_valid_i,
    .pix_i,
    .pix_ready_o,
    .res_valid_o,
    .res_o,
    .res_ready_i,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("testbench NOT OK");
    $finish;
  end

  // Result side: check every transfer, then pick next cycle's ready: at random, high while steady.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o && res_ready_i) board.check_result(res_o);
      res_ready_i <= steady || ($urandom_range(99) >= 30);
    end
  end

  // Drive one pixel; hold valid and payload until the transfer happens.
  task automatic send_pixel(input pix_t p);
    if (!steady && $urandom_range(99) < 30) begin
      pix_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    pix_valid_i <= 1'b1;
    pix_i <= p;
    do @(posedge clk_i); while (!pix_ready_o);
    board.note_pixel(p);
  endtask

  // Drop valid and wait until every owed result is back and the pipe has drained.
  task automatic settle();
    pix_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.owed.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic set_frame(input logic [11:0] w, input logic [11:0] h,
                           input logic [11:0] lv);
    settle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_LEVEL_COUNT, lv);
    phases++;
  endtask

  // Draw a pixel: uniform, clustered around a few colors, or saturated channels.
  function automatic pix_t rand_pixel(input int unsigned flavor);
    pix_t p;
    logic [23:0] base;
    case (flavor)
      0: p = pix_t'(24'($urandom));
      1: begin
        case ($urandom_range(2))
          0: base = 24'h202020;
          1: base = 24'hc08040;
          default: base = 24'he0e0f0;
        endcase
        p.pix_red = base[23:16] + 8'($urandom_range(15));
        p.pix_green = base[15:8] + 8'($urandom_range(15));
        p.pix_blue = base[7:0] + 8'($urandom_range(15));
      end
      default: begin
        p.pix_red = $urandom_range(1) ? 8'hff : 8'h00;
        p.pix_green = $urandom_range(1) ? 8'hff : 8'h00;
        p.pix_blue = $urandom_range(1) ? 8'hff : 8'h00;
      end
    endcase
    return p;
  endfunction

  initial begin
    logic [23:0] directed [24];
    int unsigned sent, w, h, lv, n;
    directed = '{
      24'hffffff, 24'hffffff, 24'hffffff,
      24'h000000, 24'h000000, 24'h000000,
      24'hff0000, 24'h00ff00, 24'h0000ff,
      24'hfeffff, 24'h010101, 24'h808080,
      24'h000000, 24'hffffff, 24'h000000,
      24'hffffff, 24'h000000, 24'hffffff,
      24'h000000, 24'hffffff, 24'h7f7f7f,
      24'hfffffe, 24'h555555, 24'haaaaaa
    };
    board = new();
    steady = 1'b0;
    phases = 0;
    rst_ni = 1'b0;
    pix_valid_i = 1'b0;
    pix_i = '0;
    res_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: saturated pixels, black/white ties, full intensity, two 3x4 frames.
    set_frame(3, 4, 10);
    foreach (directed[i]) send_pixel(pix_t'(directed[i]));

    // Out-of-range sizes and levels clamp to their limits.
    set_frame(0, 1, 0);
    repeat (27) send_pixel(rand_pixel(2));
    set_frame(12, 3, 31);
    repeat (60) send_pixel(rand_pixel($urandom_range(2)));
    set_frame(3, 4095, 1);
    repeat (60) send_pixel(rand_pixel(1));

    // Random frames: mostly whole small frames, some cut short or with level changes.
    sent = 0;
    while (sent < 530) begin
      steady = (sent >= 200 && sent < 330);
      if ($urandom_range(9) == 0) begin
        settle();
        write_reg(RegSpare, 12'($urandom));
        write_reg(REG_LEVEL_COUNT, 12'($urandom));
      end else begin
        w = ($urandom_range(7) == 0) ? $urandom_range(0, 40) : $urandom_range(3, 9);
        h = ($urandom_range(7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
        lv = $urandom_range(0, 31);
        set_frame(w, h, lv);
      end
      w = (board.width_reg < 3) ? 3 : board.width_reg;
      h = (board.height_reg < 3) ? 3 : board.height_reg;
      n = $urandom_range(3) == 0 ? $urandom_range(1, w * h) : w * h * $urandom_range(1, 2);
      if (n > 530 - sent) n = 530 - sent;
      repeat (n) send_pixel(rand_pixel($urandom_range(2)));
      sent += n;
    end
    steady = 1'b0;
    settle();

    $display("covered %0d pixels in %0d frame settings, %0d filtered pixels checked",
             board.pixels, phases, board.matched);
    if (board.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule

`default_nettype wire
